// ===== rtl/core/rdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared widths, character constants and types of the radix digit formatter.
// ----------------------------------------------------------------------------
package rdf_pkg;

    // conversion width and derived widths
    localparam int VALUE_BITS = 31;
    localparam int BASE_W     = 5;
    localparam int CHAR_W     = 8;
    localparam int REM_W      = 4;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int DIG_W      = $clog2(VALUE_BITS);

    // radix limits and ascii codes
    localparam logic [BASE_W-1:0] RADIX_MIN     = BASE_W'(2);
    localparam logic [BASE_W-1:0] RADIX_MAX     = BASE_W'(16);
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = CHAR_W'(65);
    localparam logic [CHAR_W-1:0] CHAR_NONE     = CHAR_W'(0);
    localparam logic [REM_W-1:0]  DEC_LIMIT     = REM_W'(9);
    localparam logic [REM_W-1:0]  DEC_SPAN      = REM_W'(10);

    // request into the shared divider
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [BASE_W-1:0]     divisor;
    } t_div_req;

    // result out of the shared divider
    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quot;
        logic [REM_W-1:0]      rem;
    } t_div_rsp;

    // digit value to ascii character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DEC_LIMIT) begin
            c = ASCII_UPPER_A + CHAR_W'(d - DEC_SPAN);
        end else begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/rdf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_in_if
// Input channel: value and radix with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdf_in_if;
    logic                          valid;
    logic                          ready;
    logic [rdf_pkg::VALUE_BITS-1:0] value;
    logic [rdf_pkg::BASE_W-1:0]     base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

// ===== rtl/core/rdf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_out_if
// Output channel: one ascii character per transfer with last and error flags.
// ----------------------------------------------------------------------------
interface rdf_out_if;
    logic                       valid;
    logic                       ready;
    logic [rdf_pkg::CHAR_W-1:0] digit_char;
    logic                       last;
    logic                       bad_base;

    modport source (output valid, output digit_char, output last, output bad_base,
                    input ready);
    modport sink   (input valid, input digit_char, input last, input bad_base,
                    output ready);
endinterface

// ===== rtl/core/rdf_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_divider
// Restoring divider, one quotient bit per cycle, shared by every digit.
// ----------------------------------------------------------------------------
module rdf_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdf_pkg::t_div_req i_req,
    output rdf_pkg::t_div_rsp o_rsp
);

    logic [rdf_pkg::VALUE_BITS-1:0] r_quot, n_quot;
    logic [rdf_pkg::REM_W-1:0]      r_rem, n_rem;
    logic [rdf_pkg::BASE_W-1:0]     r_div, n_div;
    logic [rdf_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [rdf_pkg::REM_W:0]        trial;
    logic                           fits;

    // partial remainder with the next dividend bit shifted in
    assign trial = {r_rem, r_quot[rdf_pkg::VALUE_BITS-1]};
    assign fits  = (trial >= r_div);

    // one iteration step
    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
            n_cnt  = rdf_pkg::CNT_W'(rdf_pkg::VALUE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[rdf_pkg::VALUE_BITS-2:0], fits};
            n_rem  = fits ? rdf_pkg::REM_W'(trial - r_div) : trial[rdf_pkg::REM_W-1:0];
            n_cnt  = r_cnt - rdf_pkg::CNT_W'(1);
            if (r_cnt == rdf_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/core/radix_digit_formatter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_formatter_top
// Converts a non-negative integer to ascii digits in radix 2 to 16.
// ----------------------------------------------------------------------------
// Each accepted value is divided repeatedly by its radix in one shared
// restoring divider that yields a quotient bit per cycle; the digits are kept
// in a small buffer and then sent most significant first, each character
// passing through S_PREP, which reads the buffer, and S_EMIT, which waits
// while the sink holds off. A radix outside 2..16 yields a single error
// character (code 0, last and bad_base set). The input is ready only while
// the block is idle and the output register is free or being drained.
// ----------------------------------------------------------------------------
module radix_digit_formatter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdf_in_if.sink    i_in,
    rdf_out_if.source o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PREP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [rdf_pkg::BASE_W-1:0]     r_base, n_base;
    logic [rdf_pkg::DIG_W-1:0]      r_idx, n_idx;
    logic                           r_ov, n_ov;
    logic [rdf_pkg::CHAR_W-1:0]     r_char, n_char;
    logic                           r_last, n_last;
    logic                           r_bad, n_bad;
    logic [rdf_pkg::REM_W-1:0]      r_rd;
    logic [rdf_pkg::REM_W-1:0]      r_mem [rdf_pkg::VALUE_BITS];
    logic                           wr_en;
    logic                           slot_free;
    logic                           in_xfer;
    logic                           base_ok;
    rdf_pkg::t_div_req              div_req;
    rdf_pkg::t_div_rsp              div_rsp;

    // shared divider
    rdf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // handshake terms
    assign slot_free   = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && slot_free;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign base_ok     = i_in.base inside {[rdf_pkg::RADIX_MIN:rdf_pkg::RADIX_MAX]};

    // sequencer
    always_comb begin
        n_state          = r_state;
        n_base           = r_base;
        n_idx            = r_idx;
        n_ov             = r_ov;
        n_char           = r_char;
        n_last           = r_last;
        n_bad            = r_bad;
        wr_en            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quot;
        div_req.divisor  = r_base;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (base_ok) begin
                        n_base           = i_in.base;
                        n_idx            = '0;
                        div_req.start    = 1'b1;
                        div_req.dividend = i_in.value;
                        div_req.divisor  = i_in.base;
                        n_state          = S_DIV;
                    end else begin
                        n_ov   = 1'b1;
                        n_char = rdf_pkg::CHAR_NONE;
                        n_last = 1'b1;
                        n_bad  = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    wr_en = 1'b1;
                    if (div_rsp.quot == '0) begin
                        n_state = S_PREP;
                    end else begin
                        div_req.start = 1'b1;
                        n_idx         = r_idx + rdf_pkg::DIG_W'(1);
                    end
                end
            end
            S_PREP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ov   = 1'b1;
                    n_char = rdf_pkg::digit_to_ascii(r_rd);
                    n_last = (r_idx == '0);
                    n_bad  = 1'b0;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - rdf_pkg::DIG_W'(1);
                        n_state = S_PREP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_idx   <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_char <= n_char;
        r_last <= n_last;
        r_bad  <= n_bad;
    end

    // digit buffer, least significant digit at index zero
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= div_rsp.rem;
        end
    end

    // registered read of the digit to send next
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx];
    end

    // output transfer
    assign o_out.valid      = r_ov;
    assign o_out.digit_char = r_char;
    assign o_out.last       = r_last;
    assign o_out.bad_base   = r_bad;

endmodule
